// ===== hw/rtl/ecsm_pkg.sv =====
// ecsm_pkg: shared types and codes for the elliptic curve scalar multiply core
// no dependencies
package ecsm_pkg;

  // configuration register indexes
  localparam logic REG_FIELD_PRIME = 1'b0;
  localparam logic REG_CURVE_A     = 1'b1;

  // datapath micro-operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,      // latch inputs, start reduction of x
    OP_RED_Y,     // start reduction of y
    OP_RED_A,     // start reduction of a
    OP_NEG,       // negate point / magnitude of scalar
    OP_MUL,       // start field multiply mul_a * mul_b
    OP_SET_MA,    // write early-resolved addition to the destination
    OP_ADD_CHK,   // latch the destination of the point addition
    OP_DBL_NUM,   // num = 3*sq + a, den_in = 2y
    OP_ADD_NUM,   // num = ty - sy, den_in = tx - sx
    OP_INV_INIT,  // inverse exponent setup
    OP_INV_STEP,  // consume exponent bit
    OP_LAM,       // unused, no datapath action
    OP_X3,        // x3 from lam^2
    OP_Y3,        // dif = sx - x3 for y3 = lam*dif - sy
    OP_COMMIT,    // write sum to destination
    OP_SHIFT      // shift scalar
  } dp_op_t;

  // multiplier operand selects
  typedef enum logic [2:0] {
    MS_SX, MS_LAM, MS_RES, MS_BASE, MS_NUM, MS_DIF
  } mul_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RX, ST_RY, ST_RA, ST_WAITR, ST_NEG, ST_ROUND, ST_ACHK,
    ST_SQ, ST_SQW, ST_DNUM, ST_ANUM, ST_IINIT, ST_ILOOP, ST_IMULR,
    ST_IMULRW, ST_IMULB, ST_IMULBW, ST_LAM, ST_LAMW, ST_X3, ST_X3W,
    ST_Y3, ST_Y3W, ST_COMMIT, ST_NEXT, ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t   op;
    mul_sel_t sel_a;
    mul_sel_t sel_b;
    logic     dst_acc;   // current addition targets the accumulator
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic unit_done;    // reducer or multiplier finished this cycle
    logic p_bad;        // modulus below 3
    logic trivial;      // zero scalar or infinite base
    logic k_neg;
    logic k_bit;
    logic k_zero;
    logic add_early;    // addition resolved without arithmetic
    logic add_dbl;      // addition is a doubling
    logic den_zero;     // inversion of zero
    logic e_zero;
    logic e_bit;
    logic err;
  } dp_status_t;

endpackage

// ===== hw/rtl/ec_point_scalar_multiply_core.sv =====
// ec_point_scalar_multiply_core: top level of the scalar multiply block
// depends on ecsm_pkg, ecsm_ctrl, ecsm_datapath, ecsm_modmul
//
// usage:
//   configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
//   the field prime, index 1 the curve coefficient a; cfg_ready is always high.
//   write only while busy is low.
//   input: a transaction is accepted when start is high and busy is low.
//   output: out_valid pulses for one cycle with the product point and flags.
//   the receiver cannot stall; results are simply presented once.
// sequence: three reductions, then per scalar bit an optional addition into
//   the accumulator and a doubling; each one not resolved early runs one
//   Fermat inversion of up to 2*FIELD_BITS multiplies on the single bit-serial
//   multiplier plus three (addition) or four (doubling) more multiplies.
//   a zero scalar or infinite base gives the result right after the
//   reductions; a modulus below 3 skips them and goes straight to done.
//   one item at a time: busy stays high until the result cycle.
// reset: rst_n low synchronously returns to idle and loads prime 17, a = 2.
module ec_point_scalar_multiply_core
  import ecsm_pkg::*;
#(
  parameter int FIELD_BITS = 63
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [62:0]           cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [62:0]           in_base_x,
  input  logic [62:0]           in_base_y,
  input  logic                  in_base_is_infinity,
  input  logic signed [63:0]    in_scalar,
  output logic                  out_valid,
  output logic [62:0]           out_result_x,
  output logic [62:0]           out_result_y,
  output logic                  out_result_is_infinity,
  output logic                  out_inverse_error
);
  localparam int W = FIELD_BITS;

  logic [62:0]  prime_r, ca_r;
  dp_cmd_t      cmd;
  dp_status_t   st;
  logic         fin, fin_err, rinf;
  logic [W-1:0] rx, ry;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r <= 63'd17;
      ca_r    <= 63'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIELD_PRIME: prime_r <= cfg_data;
        REG_CURVE_A:     ca_r <= cfg_data;
      endcase
    end
  end

  ecsm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .st(st), .cmd(cmd),
    .busy(busy), .fin(fin), .fin_err(fin_err)
  );

  ecsm_datapath #(.W(W)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .p_in(prime_r[W-1:0]), .a_in(ca_r[W-1:0]),
    .bx(in_base_x[W-1:0]), .by(in_base_y[W-1:0]), .binf(in_base_is_infinity),
    .k_in(in_scalar), .st(st), .rx(rx), .ry(ry), .rinf(rinf)
  );

  // result outputs
  always_comb begin
    out_valid              = fin;
    out_inverse_error      = fin_err;
    out_result_is_infinity = fin_err ? 1'b1 : rinf;
    out_result_x           = fin_err ? '0 : 63'(rx);
    out_result_y           = fin_err ? '0 : 63'(ry);
  end

  a_busy_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("start not taken");
  a_err_inf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inverse_error |-> out_result_is_infinity) else $error("error not inf");
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");
endmodule

// ===== hw/rtl/ecsm_modmul.sv =====
// ecsm_modmul: bit-serial modular multiply and reduce, one bit per cycle
// depends on nothing but its ports
module ecsm_modmul #(
  parameter int W = 63
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic         reduce,   // compute a mod p instead of a*b mod p
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] p,
  output logic         done,
  output logic [W-1:0] y
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc_r, acc_nxt, a_r, b_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, red_r;
  logic [W:0]    dbl, dbl_m, s1, s1_m;
  logic [W-1:0]  addend;

  // double the accumulator, then add a if the bit of b is set (multiply) or the bit itself (reduce)
  always_comb begin
    dbl    = {acc_r, 1'b0};
    dbl_m  = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
    addend = red_r ? {{(W-1){1'b0}}, b_r[W-1]} : (b_r[W-1] ? a_r : '0);
    s1     = dbl_m + {1'b0, addend};
    s1_m   = (s1 >= {1'b0, p}) ? s1 - {1'b0, p} : s1;
    acc_nxt = s1_m[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= reduce ? a : b;
      red_r <= reduce;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[W-2:0], 1'b0};
    end
  end

  assign y = acc_r;
endmodule

// ===== hw/rtl/ecsm_datapath.sv =====
// ecsm_datapath: point registers, scalar, inversion exponent and field arithmetic
// depends on ecsm_pkg and ecsm_modmul
module ecsm_datapath
  import ecsm_pkg::*;
#(
  parameter int W = 63
) (
  input  logic         clk,
  input  logic         rst_n,
  input  dp_cmd_t      cmd,
  input  logic [W-1:0] p_in,
  input  logic [W-1:0] a_in,
  input  logic [W-1:0] bx,
  input  logic [W-1:0] by,
  input  logic         binf,
  input  logic [63:0]  k_in,
  output dp_status_t   st,
  output logic [W-1:0] rx,
  output logic [W-1:0] ry,
  output logic         rinf
);
  logic [W-1:0] p_r, a_r, qx_r, qy_r, ax_r, ay_r;
  logic         qinf_r, ainf_r, err_r, dst_r;
  logic [63:0]  k_r;
  logic [W-1:0] num_r, den_r, lam_r, sq_r, x3_r, y3_r, res_r, base_r, e_r, dif_r;
  logic [2:0]   red_ph_r;
  logic [W-1:0] sx, sy, tx, ty;
  logic         sinf, tinf;
  logic [W-1:0] ma, mb, mq;
  logic         mgo, mred, mdone;

  ecsm_modmul #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .go(mgo), .reduce(mred), .a(ma), .b(mb),
    .p(p_r), .done(mdone), .y(mq)
  );

  function automatic logic [W-1:0] fadd(input logic [W-1:0] x, input logic [W-1:0] z,
                                        input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, z};
    return (s >= {1'b0, m}) ? W'(s - {1'b0, m}) : s[W-1:0];
  endfunction

  function automatic logic [W-1:0] fsub(input logic [W-1:0] x, input logic [W-1:0] z,
                                        input logic [W-1:0] m);
    return (x >= z) ? x - z : x + (m - z);
  endfunction

  function automatic logic [W-1:0] opsel(input mul_sel_t s, input logic [W-1:0] vsx,
    input logic [W-1:0] vlam, input logic [W-1:0] vres, input logic [W-1:0] vbase,
    input logic [W-1:0] vnum, input logic [W-1:0] vdif);
    case (s)
      MS_SX:   return vsx;
      MS_LAM:  return vlam;
      MS_RES:  return vres;
      MS_BASE: return vbase;
      MS_NUM:  return vnum;
      default: return vdif;
    endcase
  endfunction

  // operands of the current addition: s is the destination
  always_comb begin
    sx   = dst_r ? ax_r : qx_r;
    sy   = dst_r ? ay_r : qy_r;
    sinf = dst_r ? ainf_r : qinf_r;
    tx   = qx_r;
    ty   = qy_r;
    tinf = qinf_r;
  end

  // multiplier launch
  always_comb begin
    mred = 1'b0;
    mgo  = 1'b0;
    ma   = opsel(cmd.sel_a, sx, lam_r, res_r, base_r, num_r, dif_r);
    mb   = opsel(cmd.sel_b, sx, lam_r, res_r, base_r, num_r, dif_r);
    unique case (cmd.op)
      OP_LOAD:  begin mgo = 1'b1; mred = 1'b1; ma = bx; end
      OP_RED_Y: begin mgo = 1'b1; mred = 1'b1; ma = qy_r; end
      OP_RED_A: begin mgo = 1'b1; mred = 1'b1; ma = a_r; end
      OP_MUL:   mgo = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r    <= 1'b0;
      red_ph_r <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          p_r <= p_in; a_r <= a_in; k_r <= k_in; qinf_r <= binf; qy_r <= by;
          ax_r <= '0; ay_r <= '0; ainf_r <= 1'b1; err_r <= 1'b0;
          red_ph_r <= 3'd1;
        end
        OP_NEG: begin
          if (k_r[63]) begin
            k_r  <= ~k_r + 64'd1;
            qy_r <= fsub('0, qy_r, p_r);
          end
        end
        OP_ADD_CHK: ;
        OP_DBL_NUM: begin
          num_r  <= fadd(fadd(fadd(sq_r, sq_r, p_r), sq_r, p_r), a_r, p_r);
          base_r <= fadd(sy, sy, p_r);
          if (fadd(sy, sy, p_r) == '0) err_r <= 1'b1;
        end
        OP_ADD_NUM: begin
          num_r  <= fsub(ty, sy, p_r);
          base_r <= fsub(tx, sx, p_r);
          if (fsub(tx, sx, p_r) == '0) err_r <= 1'b1;
        end
        OP_INV_INIT: begin
          res_r <= W'(1);
          e_r   <= p_r - W'(2);
        end
        OP_INV_STEP: e_r <= e_r >> 1;
        OP_LAM:  ;
        OP_X3:   x3_r <= fsub(fsub(mq, sx, p_r), tx, p_r);
        OP_Y3:   dif_r <= fsub(sx, x3_r, p_r);
        OP_COMMIT: begin
          if (dst_r) begin ax_r <= x3_r; ay_r <= y3_r; ainf_r <= 1'b0; end
          else begin qx_r <= x3_r; qy_r <= y3_r; qinf_r <= 1'b0; end
        end
        OP_SHIFT: k_r <= k_r >> 1;
        default: ;
      endcase
      if (cmd.op == OP_ADD_CHK) dst_r <= cmd.dst_acc;
      // early-resolved additions write straight to the destination
      if (cmd.op == OP_SET_MA) begin
        if (sinf) begin
          if (dst_r) begin ax_r <= tx; ay_r <= ty; ainf_r <= tinf; end
        end else if (!tinf && sx == tx && fadd(sy, ty, p_r) == '0) begin
          if (dst_r) ainf_r <= 1'b1; else qinf_r <= 1'b1;
        end
      end
      // unit results by phase
      if (mdone) begin
        unique case (red_ph_r)
          3'd1: begin qx_r <= mq; red_ph_r <= 3'd2; end
          3'd2: begin qy_r <= mq; red_ph_r <= 3'd3; end
          3'd3: begin a_r <= mq; red_ph_r <= 3'd0; end
          default: ;
        endcase
        if (red_ph_r == 3'd0) begin
          unique case (cmd.sel_a)
            MS_SX:   sq_r <= mq;
            MS_RES:  res_r <= mq;
            MS_BASE: base_r <= mq;
            MS_NUM:  lam_r <= mq;
            MS_DIF:  y3_r <= fsub(mq, sy, p_r);
            default: x3_r <= fsub(fsub(mq, sx, p_r), tx, p_r);
          endcase
        end
      end
    end
  end

  always_comb begin
    st.unit_done = mdone;
    st.p_bad     = p_in < W'(3);
    st.trivial   = (k_r == 64'd0) || qinf_r;
    st.k_neg     = k_r[63];
    st.k_bit     = k_r[0];
    st.k_zero    = k_r == 64'd0;
    st.add_early = sinf || tinf || (sx == tx && fadd(sy, ty, p_r) == '0)
                   || (sx == tx && sy == ty && sy == '0);
    st.add_dbl   = sx == tx && sy == ty;
    st.den_zero  = err_r;
    st.e_zero    = e_r == '0;
    st.e_bit     = e_r[0];
    st.err       = err_r;
  end

  assign rx   = ainf_r ? '0 : ax_r;
  assign ry   = ainf_r ? '0 : ay_r;
  assign rinf = ainf_r;
endmodule

// ===== hw/rtl/ecsm_ctrl.sv =====
// ecsm_ctrl: sequencer for reduction, double-and-add rounds and Fermat inversion
// depends on ecsm_pkg
module ecsm_ctrl
  import ecsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t st,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       fin,
  output logic       fin_err
);
  state_t state_r, state_nxt;
  logic   dst_r, dst_nxt, fin_nxt, ferr_nxt, perr_r, perr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dst_r   <= 1'b0;
      fin     <= 1'b0;
      fin_err <= 1'b0;
      perr_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dst_r   <= dst_nxt;
      fin     <= fin_nxt;
      fin_err <= ferr_nxt;
      perr_r  <= perr_nxt;
    end
  end

  assign busy = state_r != ST_IDLE;

  always_comb begin
    state_nxt = state_r;
    dst_nxt   = dst_r;
    fin_nxt   = 1'b0;
    ferr_nxt  = 1'b0;
    perr_nxt  = perr_r;
    cmd.op    = OP_NONE;
    cmd.sel_a = MS_SX;
    cmd.sel_b = MS_SX;
    cmd.dst_acc = dst_r;
    unique case (state_r)
      ST_IDLE: if (start) begin
        perr_nxt = st.p_bad;
        if (!st.p_bad) cmd.op = OP_LOAD;
        state_nxt = st.p_bad ? ST_DONE : ST_RX;
      end
      ST_RX: if (st.unit_done) begin cmd.op = OP_RED_Y; state_nxt = ST_RY; end
      ST_RY: if (st.unit_done) begin cmd.op = OP_RED_A; state_nxt = ST_RA; end
      ST_RA: if (st.unit_done) state_nxt = ST_WAITR;
      ST_WAITR: state_nxt = st.trivial ? ST_DONE : ST_NEG;
      ST_NEG: begin cmd.op = OP_NEG; state_nxt = ST_ROUND; end
      ST_ROUND: begin
        if (st.k_zero || st.err) state_nxt = ST_DONE;
        else begin
          dst_nxt = st.k_bit;
          state_nxt = ST_ACHK;
          cmd.op = OP_ADD_CHK; cmd.dst_acc = st.k_bit;
        end
      end
      ST_ACHK: begin
        if (st.add_early) begin
          cmd.op = OP_SET_MA; state_nxt = ST_NEXT;
        end else if (st.add_dbl) begin
          cmd.op = OP_MUL; cmd.sel_a = MS_SX; cmd.sel_b = MS_SX; state_nxt = ST_SQW;
        end else begin
          cmd.op = OP_ADD_NUM; state_nxt = ST_IINIT;
        end
      end
      ST_SQW: begin
        cmd.sel_a = MS_SX;
        if (st.unit_done) state_nxt = ST_DNUM;
      end
      ST_DNUM: begin cmd.op = OP_DBL_NUM; state_nxt = ST_IINIT; end
      ST_IINIT: begin
        if (st.den_zero) state_nxt = ST_DONE;
        else begin cmd.op = OP_INV_INIT; state_nxt = ST_ILOOP; end
      end
      ST_ILOOP: begin
        if (st.e_zero) state_nxt = ST_LAM;
        else if (st.e_bit) begin
          cmd.op = OP_MUL; cmd.sel_a = MS_RES; cmd.sel_b = MS_BASE; state_nxt = ST_IMULRW;
        end else begin
          cmd.op = OP_MUL; cmd.sel_a = MS_BASE; cmd.sel_b = MS_BASE; state_nxt = ST_IMULBW;
        end
      end
      ST_IMULRW: begin
        cmd.sel_a = MS_RES;
        if (st.unit_done) begin
          cmd.op = OP_NONE; state_nxt = ST_IMULB;
        end
      end
      ST_IMULB: begin
        cmd.op = OP_MUL; cmd.sel_a = MS_BASE; cmd.sel_b = MS_BASE; state_nxt = ST_IMULBW;
      end
      ST_IMULBW: begin
        cmd.sel_a = MS_BASE;
        if (st.unit_done) begin cmd.op = OP_INV_STEP; state_nxt = ST_ILOOP; end
      end
      ST_LAM: begin
        cmd.op = OP_MUL; cmd.sel_a = MS_NUM; cmd.sel_b = MS_RES; state_nxt = ST_LAMW;
      end
      ST_LAMW: begin
        cmd.sel_a = MS_NUM;
        if (st.unit_done) state_nxt = ST_X3;
      end
      ST_X3: begin
        cmd.op = OP_MUL; cmd.sel_a = MS_LAM; cmd.sel_b = MS_LAM; state_nxt = ST_X3W;
      end
      ST_X3W: begin
        cmd.sel_a = MS_LAM;
        if (st.unit_done) state_nxt = ST_Y3;
      end
      ST_Y3: begin cmd.op = OP_Y3; state_nxt = ST_Y3W; end
      ST_Y3W: begin
        cmd.op = OP_MUL; cmd.sel_a = MS_DIF; cmd.sel_b = MS_LAM; state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.sel_a = MS_DIF;
        if (st.unit_done) state_nxt = ST_IMULR;
      end
      ST_IMULR: begin cmd.op = OP_COMMIT; state_nxt = ST_NEXT; end
      ST_NEXT: begin
        if (dst_r) begin
          dst_nxt = 1'b0; cmd.dst_acc = 1'b0;
          cmd.op = OP_ADD_CHK; state_nxt = ST_ACHK;
        end else begin
          cmd.op = OP_SHIFT; state_nxt = ST_ROUND;
        end
      end
      ST_DONE: begin
        fin_nxt = 1'b1; ferr_nxt = st.err || perr_r; state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
